// ----- hw/rtl/masked_pixel_tint_unit_assert.svh -----
// Assertion macros for the masked pixel tint unit (sampled on clk, off during reset)
`ifndef MASKED_PIXEL_TINT_UNIT_ASSERT_SVH
`define MASKED_PIXEL_TINT_UNIT_ASSERT_SVH

// Same-cycle implication
`define MPT_ASSERT_NOW(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("mpt same-cycle check failed");

// Next-cycle implication
`define MPT_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("mpt next-cycle check failed");

`endif

// ----- hw/rtl/mpt_pkg.sv -----
// Package: shared types, constants and the magnitude factor table for the tint unit
`timescale 1ns / 1ps
`default_nettype none

package mpt_pkg;

    localparam int unsigned PIX_W  = 24;
    localparam int unsigned CHAN_W = 8;

    // Magnitudes at or below this scale linearly
    localparam logic [CHAN_W-1:0] LOW_LIMIT = 8'd104;
    // Brightening numerator: 256 * LOW_LIMIT
    localparam int unsigned HIGH_NUM = 26624;
    // Numerator width for the table's long division
    localparam int unsigned HIGH_NUM_W = 15;

    // p / 104 == (p * RECIP_MUL) >> RECIP_SHIFT for p < 2^15
    localparam int unsigned     RECIP_SHIFT = 21;
    localparam logic [14:0]     RECIP_MUL   = 15'd20165;
    localparam int unsigned     LOWP_W      = 30;

    typedef logic [CHAN_W-1:0] ftab_t [256];

    // Per magnitude: the magnitude itself on the linear side, floor(26624/m) above it
    function automatic ftab_t build_factor_table();
        ftab_t       tab;
        int unsigned rem;
        int unsigned quo;
        for (int i = 0; i < 256; i++)
        begin
            if (i <= int'(LOW_LIMIT))
                tab[i] = CHAN_W'(i);
            else
            begin
                // Restoring long division of HIGH_NUM by the magnitude
                rem = 0;
                quo = 0;
                for (int b = HIGH_NUM_W - 1; b >= 0; b--)
                begin
                    rem = (rem << 1) | ((HIGH_NUM >> b) & 1);
                    quo = quo << 1;
                    if (rem >= unsigned'(i))
                    begin
                        rem = rem - unsigned'(i);
                        quo = quo | 1;
                    end
                end
                tab[i] = CHAN_W'(quo);
            end
        end
        return tab;
    endfunction

    localparam ftab_t FACTOR_TABLE = build_factor_table();

    // Stage 1 payload handed from decode to the channel datapaths
    typedef struct packed {
        logic              pass;
        logic              low;
        logic [CHAN_W-1:0] k;
        logic [PIX_W-1:0]  tint;
        logic [PIX_W-1:0]  src;
    } mpt_s1_t;

endpackage

`default_nettype wire

// ----- hw/rtl/mpt_if.sv -----
// Interfaces: pixel input, pixel output and tint configuration channels
`timescale 1ns / 1ps
`default_nettype none

interface mpt_pix_in_if;
    logic        valid;
    logic        ready;
    logic [23:0] src_pixel;
    logic [23:0] mask_pixel;
    modport source (output valid, output src_pixel, output mask_pixel, input ready);
    modport sink   (input valid, input src_pixel, input mask_pixel, output ready);
endinterface

interface mpt_pix_out_if;
    logic        valid;
    logic        ready;
    logic [23:0] out_pixel;
    modport source (output valid, output out_pixel, input ready);
    modport sink   (input valid, input out_pixel, output ready);
endinterface

interface mpt_cfg_if;
    logic        valid;
    logic        ready;
    logic [23:0] tint_color;
    modport source (output valid, output tint_color, input ready);
    modport sink   (input valid, input tint_color, output ready);
endinterface

`default_nettype wire

// ----- hw/rtl/mpt_decode.sv -----
// Stage 1: mask test, magnitude range check and factor table lookup
`timescale 1ns / 1ps
`default_nettype none

module mpt_decode
    import mpt_pkg::*;
(
    input  wire logic             clk,
    input  wire logic             adv,
    input  wire logic [PIX_W-1:0] src_pixel,
    input  wire logic [PIX_W-1:0] mask_pixel,
    input  wire logic [PIX_W-1:0] tint,
    output mpt_s1_t               s1
);

    mpt_s1_t           s1_reg;
    mpt_s1_t           s1_next;
    logic [CHAN_W-1:0] mag;

    // Red channel of the source is the magnitude
    always_comb
    begin
        mag          = src_pixel[PIX_W-1 -: CHAN_W];
        s1_next.pass = (mask_pixel != '0);
        s1_next.low  = (mag <= LOW_LIMIT);
        s1_next.k    = FACTOR_TABLE[mag];
        s1_next.tint = tint;
        s1_next.src  = src_pixel;
    end

    always_ff @(posedge clk)
    begin
        if (adv)
            s1_reg <= s1_next;
    end

    assign s1 = s1_reg;

endmodule

`default_nettype wire

// ----- hw/rtl/mpt_chan.sv -----
// Stages 2-4 of one color channel: scale, divide or brighten, select
`timescale 1ns / 1ps
`default_nettype none

module mpt_chan
    import mpt_pkg::*;
(
    input  wire logic              clk,
    input  wire logic              adv,
    input  wire logic [CHAN_W-1:0] t,
    input  wire logic [CHAN_W-1:0] k,
    input  wire logic              low,
    output logic [CHAN_W-1:0]      res
);

    // Stage 2: tint times factor
    logic [2*CHAN_W-1:0] prod_reg;
    logic [CHAN_W-1:0]   k2_reg;
    logic                low2_reg;

    // Stage 3: reciprocal product for the linear side, brightened value otherwise
    logic [LOWP_W-1:0]   lowp_reg;
    logic [LOWP_W-1:0]   lowp_next;
    logic [CHAN_W-1:0]   high_reg;
    logic [CHAN_W-1:0]   high_next;
    logic [CHAN_W:0]     high_sum;
    logic                low3_reg;

    // Stage 4: final channel value
    logic [CHAN_W-1:0]   res_reg;
    logic [CHAN_W-1:0]   res_next;

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            prod_reg <= t * k;
            k2_reg   <= k;
            low2_reg <= low;
        end
    end

    // Linear: divide by 104 via reciprocal; high: tint*f/256 + (256 - f), clamped
    always_comb
    begin
        lowp_next = LOWP_W'(prod_reg[14:0]) * LOWP_W'(RECIP_MUL);
        high_sum  = (CHAN_W+1)'(prod_reg[2*CHAN_W-1:CHAN_W])
                  + ((CHAN_W+1)'(256) - (CHAN_W+1)'(k2_reg));
        high_next = high_sum[CHAN_W] ? '1 : high_sum[CHAN_W-1:0];
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            lowp_reg <= lowp_next;
            high_reg <= high_next;
            low3_reg <= low2_reg;
        end
    end

    assign res_next = low3_reg ? lowp_reg[RECIP_SHIFT+CHAN_W-1:RECIP_SHIFT] : high_reg;

    always_ff @(posedge clk)
    begin
        if (adv)
            res_reg <= res_next;
    end

    assign res = res_reg;

endmodule

`default_nettype wire

// ----- hw/rtl/masked_pixel_tint_unit.sv -----
// Pipeline: input transfer to output valid through the decode, multiply, divide and select stages.
// Throughput: one pixel per cycle unless the output stalls; all four stages advance together.
// A stalled output freezes the whole pipe; input ready = output empty or taken.
// Reset (rst_n low, async) clears all stage valid bits and the tint color to 0.
// Configuration writes are always accepted and take effect on the next transfer.
`timescale 1ns / 1ps
`default_nettype none

module masked_pixel_tint_unit
    import mpt_pkg::*;
(
    input  wire logic    clk,
    input  wire logic    rst_n,
    mpt_pix_in_if.sink   pix_in,
    mpt_pix_out_if.source pix_out,
    mpt_cfg_if.sink      cfg
);

    `include "masked_pixel_tint_unit_assert.svh"

    logic             adv;
    logic [PIX_W-1:0] tint_reg;
    logic             s1_valid_reg;
    logic             s2_valid_reg;
    logic             s3_valid_reg;
    logic             out_valid_reg;
    logic             pass2_reg;
    logic             pass3_reg;
    logic             pass4_reg;
    logic [PIX_W-1:0] src2_reg;
    logic [PIX_W-1:0] src3_reg;
    logic [PIX_W-1:0] src4_reg;
    logic [PIX_W-1:0] tinted;
    mpt_s1_t          s1;

    // Global advance: the output stage is empty or being taken
    assign adv          = !out_valid_reg || pix_out.ready;
    assign pix_in.ready = adv;
    assign cfg.ready    = 1'b1;

    // Tint color register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            tint_reg <= '0;
        else if (cfg.valid)
            tint_reg <= cfg.tint_color;
    end

    // Valid bits move with the data
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            s2_valid_reg  <= 1'b0;
            s3_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else if (adv)
        begin
            s1_valid_reg  <= pix_in.valid;
            s2_valid_reg  <= s1_valid_reg;
            s3_valid_reg  <= s2_valid_reg;
            out_valid_reg <= s3_valid_reg;
        end
    end

    mpt_decode u_decode (
        .clk        (clk),
        .adv        (adv),
        .src_pixel  (pix_in.src_pixel),
        .mask_pixel (pix_in.mask_pixel),
        .tint       (tint_reg),
        .s1         (s1)
    );

    // One datapath per color channel
    for (genvar c = 0; c < 3; c++)
    begin : g_chan
        mpt_chan u_chan (
            .clk (clk),
            .adv (adv),
            .t   (s1.tint[c*CHAN_W +: CHAN_W]),
            .k   (s1.k),
            .low (s1.low),
            .res (tinted[c*CHAN_W +: CHAN_W])
        );
    end

    // Pass-through source and mask decision alongside the channel stages
    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            pass2_reg <= s1.pass;
            src2_reg  <= s1.src;
            pass3_reg <= pass2_reg;
            src3_reg  <= src2_reg;
            pass4_reg <= pass3_reg;
            src4_reg  <= src3_reg;
        end
    end

    assign pix_out.valid     = out_valid_reg;
    assign pix_out.out_pixel = pass4_reg ? src4_reg : tinted;

    `MPT_ASSERT_NOW(a_ready_when_empty, !out_valid_reg, pix_in.ready)
    `MPT_ASSERT_NEXT(a_in_to_s1, pix_in.valid && pix_in.ready, s1_valid_reg)
    `MPT_ASSERT_NEXT(a_s3_to_out, s3_valid_reg && adv, out_valid_reg)
    `MPT_ASSERT_NEXT(a_stall_holds, !adv,
        $stable({s1_valid_reg, s2_valid_reg, s3_valid_reg, out_valid_reg}))

endmodule

`default_nettype wire
